// ===== sv/klpi_pkg.sv =====
//------------------------------------------------------------------------------
// klpi_pkg
// Shared types and constants of the k-mer linear probing index.
//------------------------------------------------------------------------------
package klpi_pkg;

    localparam int KMER_BITS = 32;
    localparam int CFG_DATA_BITS = 10;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_KMER_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TABLE_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_KEYS = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_FIND = 1'b1;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
    localparam logic [1:0] STATUS_LIST_FULL = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_VALUE_READ,
        ST_VALUE_WAIT,
        ST_EMIT,
        ST_RESULT
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic clear_step;
        logic load_item;
        logic read_slot;
        logic advance;
        logic claim_slot;
        logic append_value;
        logic read_value;
        logic next_value;
        logic load_result;
        logic [1:0] result_status;
        logic result_found;
        logic result_from_value;
        logic result_last;
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic clear_done;
        logic is_find;
        logic slot_used;
        logic key_match;
        logic lap_done;
        logic limit_reached;
        logic list_full;
        logic list_empty;
        logic value_last;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/klpi_stream_if.sv =====
//------------------------------------------------------------------------------
// klpi_stream_if
// Valid/ready channel carrying one payload struct.
//------------------------------------------------------------------------------
interface klpi_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/klpi_datapath.sv =====
//------------------------------------------------------------------------------
// klpi_datapath
// Slot memories, probe address, value lists, key count and output register.
//------------------------------------------------------------------------------
module klpi_datapath #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUES_PER_KEY = 8,
    parameter int MAX_KMER_LEN = 16,
    parameter int POSITION_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  klpi_pkg::dp_cmd_t                   cmd,
    output klpi_pkg::dp_status_t                sts,
    input  logic                                cfg_write,
    input  logic [klpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [klpi_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_func,
    input  logic [klpi_pkg::KMER_BITS-1:0]      in_kmer,
    input  logic [POSITION_BITS-1:0]            in_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [POSITION_BITS-1:0]            out_found_position,
    output logic                                out_found,
    output logic                                out_last,
    output logic [1:0]                          out_status
);
    import klpi_pkg::*;

    localparam int IDX_BITS = $clog2(TABLE_DEPTH);
    localparam int TOP_LOG2 = $clog2(TABLE_DEPTH + 1) - 1;
    localparam int VAL_BITS = (VALUES_PER_KEY > 1) ? $clog2(VALUES_PER_KEY) : 1;
    localparam int CNT_BITS = $clog2(VALUES_PER_KEY + 1);
    localparam int KEY_BITS = (2 * MAX_KMER_LEN > KMER_BITS) ? KMER_BITS : 2 * MAX_KMER_LEN;
    localparam int KC_BITS = IDX_BITS + 1;
    localparam int LEN_BITS = 6;

    // Slot memories; the used bits are a memory cleared by a pass after reset.
    logic                    used_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0]     key_mem [TABLE_DEPTH];
    logic [CNT_BITS-1:0]     cnt_mem [TABLE_DEPTH];
    logic [POSITION_BITS-1:0] val_mem [TABLE_DEPTH << VAL_BITS];

    logic [4:0]              kmer_length_reg;
    logic [3:0]              table_size_log2_reg;
    logic [9:0]              max_keys_reg;
    logic                    func_reg;
    logic [KEY_BITS-1:0]     key_reg;
    logic [POSITION_BITS-1:0] pos_reg;
    logic [IDX_BITS-1:0]     idx_reg, idx_next;
    logic [IDX_BITS:0]       steps_reg;
    logic [IDX_BITS:0]       clear_reg;
    logic [KC_BITS-1:0]      key_count_reg;
    logic [IDX_BITS-1:0]     mask_reg;
    logic [IDX_BITS:0]       slots_reg;
    logic                    rd_used_reg;
    logic [KEY_BITS-1:0]     rd_key_reg;
    logic [CNT_BITS-1:0]     rd_cnt_reg;
    logic [VAL_BITS-1:0]     vsel_reg;
    logic [POSITION_BITS-1:0] rd_val_reg;
    logic                    out_valid_reg;
    logic [POSITION_BITS-1:0] out_pos_reg;
    logic                    out_found_reg, out_last_reg;
    logic [1:0]              out_status_reg;

    logic [LEN_BITS-1:0]     len_eff;
    logic [3:0]              lg_eff;
    logic [KMER_BITS-1:0]    key_mask;
    logic [KC_BITS-1:0]      limit;
    logic [IDX_BITS+VAL_BITS-1:0] vaddr;
    logic [IDX_BITS-1:0]     clear_idx;

    always_comb
    begin
        len_eff = LEN_BITS'(kmer_length_reg);
        if (kmer_length_reg == '0)
            len_eff = LEN_BITS'(1);
        if (32'(kmer_length_reg) > MAX_KMER_LEN)
            len_eff = LEN_BITS'(MAX_KMER_LEN);
        lg_eff = table_size_log2_reg;
        if (table_size_log2_reg == '0)
            lg_eff = 4'd1;
        if (32'(table_size_log2_reg) > TOP_LOG2)
            lg_eff = 4'(TOP_LOG2);
        key_mask = (len_eff >= LEN_BITS'(16)) ? '1
                 : ((KMER_BITS'(1) << (2 * len_eff)) - 1'b1);
        limit = (32'(max_keys_reg) >= 32'(slots_reg))
              ? KC_BITS'(slots_reg - 1'b1) : KC_BITS'(max_keys_reg);
        idx_next = (idx_reg + 1'b1) & mask_reg;
        clear_idx = clear_reg[IDX_BITS-1:0];
    end

    generate
        if (VALUES_PER_KEY > 1)
        begin : g_vaddr
            always_comb vaddr = {idx_reg, (cmd.append_value ? rd_cnt_reg[VAL_BITS-1:0]
                                        : (cmd.claim_slot ? VAL_BITS'(0) : vsel_reg))};
        end
        else
        begin : g_vaddr1
            always_comb vaddr = {idx_reg, 1'b0} >> 1;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_length_reg <= 5'd16;
            table_size_log2_reg <= 4'd10;
            max_keys_reg <= 10'd512;
            clear_reg <= '0;
            key_count_reg <= '0;
            out_valid_reg <= 1'b0;
            steps_reg <= '0;
            vsel_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KMER_LENGTH:     kmer_length_reg <= cfg_data[4:0];
                    CFG_TABLE_SIZE_LOG2: table_size_log2_reg <= cfg_data[3:0];
                    CFG_MAX_KEYS:        max_keys_reg <= cfg_data;
                    default:             ;
                endcase
            end
            if (cmd.clear_step)
                clear_reg <= clear_reg + 1'b1;
            if (cmd.load_item)
                steps_reg <= '0;
            else if (cmd.advance)
                steps_reg <= steps_reg + 1'b1;
            if (cmd.claim_slot)
                key_count_reg <= key_count_reg + 1'b1;
            if (cmd.load_item)
                vsel_reg <= '0;
            else if (cmd.next_value)
                vsel_reg <= vsel_reg + 1'b1;
            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            func_reg <= in_func;
            key_reg <= KEY_BITS'(in_kmer & key_mask);
            pos_reg <= in_position;
            idx_reg <= IDX_BITS'(in_kmer & key_mask) & IDX_BITS'((1 << lg_eff) - 1);
            mask_reg <= IDX_BITS'((1 << lg_eff) - 1);
            slots_reg <= (IDX_BITS+1)'(1) << lg_eff;
        end
        else if (cmd.advance)
            idx_reg <= idx_next;
        if (cmd.clear_step)
            used_mem[clear_idx] <= 1'b0;
        else if (cmd.claim_slot)
            used_mem[idx_reg] <= 1'b1;
        if (cmd.claim_slot)
            key_mem[idx_reg] <= key_reg;
        if (cmd.claim_slot)
            cnt_mem[idx_reg] <= CNT_BITS'(1);
        else if (cmd.append_value)
            cnt_mem[idx_reg] <= rd_cnt_reg + 1'b1;
        if (cmd.claim_slot || cmd.append_value)
            val_mem[vaddr] <= pos_reg;
        if (cmd.read_slot)
        begin
            rd_used_reg <= used_mem[idx_reg];
            rd_key_reg <= key_mem[idx_reg];
            rd_cnt_reg <= cnt_mem[idx_reg];
        end
        if (cmd.read_value)
            rd_val_reg <= val_mem[vaddr];
        if (cmd.load_result)
        begin
            out_pos_reg <= cmd.result_from_value ? rd_val_reg : '0;
            out_found_reg <= cmd.result_found;
            out_last_reg <= cmd.result_last;
            out_status_reg <= cmd.result_status;
        end
    end

    always_comb
    begin
        sts.clear_done = (clear_reg == (IDX_BITS+1)'(TABLE_DEPTH));
        sts.is_find = (func_reg == FUNC_FIND);
        sts.slot_used = rd_used_reg;
        sts.key_match = (rd_key_reg == key_reg);
        sts.lap_done = (steps_reg + 1'b1 >= slots_reg);
        sts.limit_reached = (key_count_reg >= limit);
        sts.list_full = (rd_cnt_reg >= CNT_BITS'(VALUES_PER_KEY));
        sts.list_empty = (rd_cnt_reg == '0);
        sts.value_last = (CNT_BITS'(vsel_reg) + 1'b1 >= rd_cnt_reg);
        sts.out_busy = out_valid_reg && !out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_found_position = out_pos_reg;
    assign out_found = out_found_reg;
    assign out_last = out_last_reg;
    assign out_status = out_status_reg;

    a_found_on_list: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_found_position != '0 |-> out_found)
        else $error("position reported without found");
    a_keycount: assert property (@(posedge clk) disable iff (!rst_n)
        key_count_reg <= KC_BITS'(TABLE_DEPTH))
        else $error("key count overflow");
    a_status_ok_find: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> out_status == STATUS_OK && out_found)
        else $error("non-final result must be a found position");
endmodule

// ===== sv/klpi_ctrl.sv =====
//------------------------------------------------------------------------------
// klpi_ctrl
// Sequencer for the clearing pass, slot probing and result emission.
//------------------------------------------------------------------------------
module klpi_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output klpi_pkg::dp_cmd_t    cmd,
    input  klpi_pkg::dp_status_t sts
);
    import klpi_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = ST_IDLE;
                else
                    cmd.clear_step = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_slot = 1'b1;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (sts.slot_used && !sts.key_match && !sts.lap_done)
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_READ;
                end
                else if (sts.is_find)
                begin
                    if (sts.slot_used && sts.key_match && !sts.list_empty)
                        state_next = ST_VALUE_READ;
                    else
                        state_next = ST_RESULT;
                end
                else
                    state_next = ST_RESULT;
            end
            ST_VALUE_READ:
            begin
                cmd.read_value = 1'b1;
                state_next = ST_VALUE_WAIT;
            end
            ST_VALUE_WAIT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    cmd.result_from_value = 1'b1;
                    cmd.result_found = 1'b1;
                    cmd.result_status = STATUS_OK;
                    cmd.result_last = sts.value_last;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.value_last)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.next_value = 1'b1;
                    state_next = ST_VALUE_READ;
                end
            end
            ST_RESULT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_result = 1'b1;
                    cmd.result_last = 1'b1;
                    state_next = ST_IDLE;
                    if (sts.is_find)
                        cmd.result_status = STATUS_OK;
                    else if (sts.slot_used && sts.key_match)
                    begin
                        cmd.result_found = 1'b1;
                        if (sts.list_full)
                            cmd.result_status = STATUS_LIST_FULL;
                        else
                            cmd.append_value = 1'b1;
                    end
                    else if (sts.slot_used || sts.limit_reached)
                        cmd.result_status = STATUS_TABLE_FULL;
                    else
                    begin
                        cmd.result_found = 1'b1;
                        cmd.claim_slot = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ready)
        else $error("input accepted during clearing pass");
    a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({cmd.claim_slot, cmd.append_value, cmd.clear_step}) <= 1)
        else $error("conflicting memory writes");
    a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.claim_slot || cmd.append_value |-> cmd.load_result)
        else $error("table written without a result");
endmodule

// ===== sv/kmer_linear_probe_index.sv =====
//------------------------------------------------------------------------------
// kmer_linear_probe_index
// k-mer index in a linear probing hash table with per-key position lists.
//------------------------------------------------------------------------------
// Usage: items enter on req (func, kmer, position); results leave on rsp
// (found_position, found, last, status). An insert gives one result; a find
// gives one result per stored position, last set on the final one, or one
// not-found result. The user writes configuration (cfg_write/cfg_index/
// cfg_data) only while the block is idle; the block does not enforce it.
// Flow: one item at a time. An accepted item probes slot by slot, each slot
// with a registered memory read, then a compare, before the result is loaded.
// A find that hits replaces the result load with, per returned position,
// a list read, a result load and a step to the next entry.
// Reset: a clearing pass walks the slot-used memory, one entry per cycle;
// req.ready stays low until it ends.
// Stall: a result waits in the output register; the sequencer holds until
// that register is free.
//------------------------------------------------------------------------------
module kmer_linear_probe_index #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUES_PER_KEY = 8,
    parameter int MAX_KMER_LEN = 16,
    parameter int POSITION_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    klpi_stream_if.sink                         req,
    klpi_stream_if.source                       rsp,
    input  logic                                cfg_write,
    input  logic [klpi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [klpi_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import klpi_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t sts;

    klpi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .sts      (sts)
    );

    klpi_datapath #(
        .TABLE_DEPTH    (TABLE_DEPTH),
        .VALUES_PER_KEY (VALUES_PER_KEY),
        .MAX_KMER_LEN   (MAX_KMER_LEN),
        .POSITION_BITS  (POSITION_BITS)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_func            (req.data.func),
        .in_kmer            (req.data.kmer),
        .in_position        (req.data.position),
        .out_valid          (rsp.valid),
        .out_ready          (rsp.ready),
        .out_found_position (rsp.data.found_position),
        .out_found          (rsp.data.found),
        .out_last           (rsp.data.last),
        .out_status         (rsp.data.status)
    );
endmodule

// ===== test/tb_kmer_types_pkg.sv =====
//------------------------------------------------------------------------------
// tb_kmer_types_pkg
// Payload structs of the request and response channels used by the testbench.
//------------------------------------------------------------------------------
package tb_kmer_types_pkg;

    typedef struct packed {
        logic        func;
        logic [31:0] kmer;
        logic [23:0] position;
    } kmer_request_t;

    typedef struct packed {
        logic [23:0] found_position;
        logic        found;
        logic        last;
        logic [1:0]  status;
    } kmer_hit_t;

endpackage

// ===== test/tb_kmer_index_checker.sv =====
//------------------------------------------------------------------------------
// tb_kmer_index_checker
// Watches the request, response and configuration ports, keeps its own copy
// of the hash table and compares every response against the predicted one.
//------------------------------------------------------------------------------
module tb_kmer_index_checker
    import klpi_pkg::*;
    import tb_kmer_types_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      req_valid,
    input  logic                      req_ready,
    input  kmer_request_t             req_data,
    input  logic                      rsp_valid,
    input  logic                      rsp_ready,
    input  kmer_hit_t                 rsp_data,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    output int                        pending,
    output int                        errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS_MAX = 1024;
    localparam int LIST_DEPTH = 8;

    logic        slot_taken [SLOTS_MAX];
    logic [31:0] slot_kmer [SLOTS_MAX];
    int          slot_fill [SLOTS_MAX];
    logic [23:0] slot_list [SLOTS_MAX][LIST_DEPTH];
    int          stored_keys;

    logic [4:0]  bases_cfg;
    logic [3:0]  size_log2_cfg;
    logic [9:0]  key_limit_cfg;

    kmer_hit_t   expected_hits[$];

    assign pending = expected_hits.size();

    function automatic kmer_hit_t make_hit(logic [23:0] pos, logic fnd, logic lst,
                                           logic [1:0] st);
        kmer_hit_t h;
        h.found_position = pos;
        h.found = fnd;
        h.last = lst;
        h.status = st;
        return h;
    endfunction

    // Appends one predicted transaction at the tail of the queue.
    function automatic void queue_hit(kmer_hit_t h);
        expected_hits = {expected_hits, h};
    endfunction

    // Applies one request to the table copy and queues the responses it causes.
    function automatic void lookup_and_update(kmer_request_t it);
        int unsigned bases;
        int unsigned lg;
        int unsigned slots;
        int unsigned idx;
        int unsigned limit;
        logic [31:0] key;
        int          outcome;
        int          at;
        begin
            bases = (bases_cfg == 0) ? 1 : ((bases_cfg > 16) ? 16 : bases_cfg);
            key = (bases == 16) ? it.kmer : (it.kmer & ((32'h1 << (2 * bases)) - 1));
            lg = (size_log2_cfg == 0) ? 1 : ((size_log2_cfg > 10) ? 10 : size_log2_cfg);
            slots = 1 << lg;
            idx = key & (slots - 1);
            // Outcome 0 is a full lap, 1 an empty slot, 2 a matching key.
            outcome = 0;
            at = 0;
            for (int n = 0; n < slots; n++)
            begin
                if (!slot_taken[idx])
                begin
                    outcome = 1;
                    at = idx;
                    break;
                end
                if (slot_kmer[idx] == key)
                begin
                    outcome = 2;
                    at = idx;
                    break;
                end
                idx = (idx + 1) & (slots - 1);
            end

            if (it.func == FUNC_FIND)
            begin
                if (outcome != 2 || slot_fill[at] == 0)
                begin
                    queue_hit(make_hit('0, 1'b0, 1'b1, STATUS_OK));
                end
                else
                begin
                    for (int i = 0; i < slot_fill[at]; i++)
                        queue_hit(make_hit(slot_list[at][i], 1'b1,
                                           i + 1 == slot_fill[at], STATUS_OK));
                end
            end
            else if (outcome == 2)
            begin
                if (slot_fill[at] >= LIST_DEPTH)
                begin
                    queue_hit(make_hit('0, 1'b1, 1'b1, STATUS_LIST_FULL));
                end
                else
                begin
                    slot_list[at][slot_fill[at]] = it.position;
                    slot_fill[at]++;
                    queue_hit(make_hit('0, 1'b1, 1'b1, STATUS_OK));
                end
            end
            else
            begin
                limit = (key_limit_cfg > slots - 1) ? slots - 1 : key_limit_cfg;
                if (outcome == 0 || stored_keys >= limit)
                begin
                    queue_hit(make_hit('0, 1'b0, 1'b1, STATUS_TABLE_FULL));
                end
                else
                begin
                    slot_taken[at] = 1'b1;
                    slot_kmer[at] = key;
                    slot_list[at][0] = it.position;
                    slot_fill[at] = 1;
                    stored_keys = (stored_keys + 1) & 11'h7FF;
                    queue_hit(make_hit('0, 1'b1, 1'b1, STATUS_OK));
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kmer_hit_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS_MAX; i++)
            begin
                slot_taken[i] = 1'b0;
                slot_fill[i] = 0;
            end
            stored_keys = 0;
            bases_cfg = 5'd16;
            size_log2_cfg = 4'd10;
            key_limit_cfg = 10'd512;
            expected_hits.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_KMER_LENGTH:     bases_cfg = cfg_data[4:0];
                    CFG_TABLE_SIZE_LOG2: size_log2_cfg = cfg_data[3:0];
                    CFG_MAX_KEYS:        key_limit_cfg = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
                lookup_and_update(req_data);
            if (rsp_valid && rsp_ready)
            begin
                if (expected_hits.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %p",
                             $time, rsp_data);
                    errors++;
                end
                else
                begin
                    want = expected_hits.pop_front();
                    if (rsp_data.found_position !== want.found_position)
                    begin
                        $display("%0t: found_position expected %h actual %h",
                                 $time, want.found_position, rsp_data.found_position);
                        errors++;
                    end
                    if (rsp_data.found !== want.found)
                    begin
                        $display("%0t: found expected %b actual %b",
                                 $time, want.found, rsp_data.found);
                        errors++;
                    end
                    if (rsp_data.last !== want.last)
                    begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, rsp_data.last);
                        errors++;
                    end
                    if (rsp_data.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_data.status);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== test/tb_top.sv =====
//------------------------------------------------------------------------------
// tb_top
// Drives directed and random inserts and finds into the k-mer index across
// several table settings, with random idling on both channels.
//------------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import klpi_pkg::*;
    import tb_kmer_types_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      calm = 1'b0;
    int                        pending;
    int                        errors;
    int                        cycles = 0;
    logic [31:0]               kmer_pool [12];

    klpi_stream_if #(.payload_t(kmer_request_t)) req_ch ();
    klpi_stream_if #(.payload_t(kmer_hit_t))     rsp_ch ();

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
    end

    always #5 clk = ~clk;

    kmer_linear_probe_index dut (
        .clk(clk),
        .rst_n(rst_n),
        .req(req_ch),
        .rsp(rsp_ch),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    tb_kmer_index_checker checker_i (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_ch.valid),
        .req_ready(req_ch.ready),
        .req_data(req_ch.data),
        .rsp_valid(rsp_ch.valid),
        .rsp_ready(rsp_ch.ready),
        .rsp_data(rsp_ch.data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pending(pending),
        .errors(errors)
    );

    always @(posedge clk)
    begin
        rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(logic func, logic [31:0] kmer, logic [23:0] position);
        kmer_request_t it;
        it.func = func;
        it.kmer = kmer;
        it.position = position;
        if (!calm && $urandom_range(0, 99) < 25)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data <= it;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Waits until every response has come back, then leaves the block idle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_table(logic [4:0] bases, logic [3:0] size_log2, logic [9:0] key_limit);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= CFG_KMER_LENGTH;
        cfg_data <= CFG_DATA_BITS'(bases);
        @(posedge clk);
        cfg_index <= CFG_TABLE_SIZE_LOG2;
        cfg_data <= CFG_DATA_BITS'(size_log2);
        @(posedge clk);
        cfg_index <= CFG_MAX_KEYS;
        cfg_data <= key_limit;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic random_phase(int count);
        logic [31:0] kmer;
        for (int i = 0; i < 12; i++)
            kmer_pool[i] = $urandom();
        for (int i = 0; i < count; i++)
        begin
            kmer = ($urandom_range(0, 99) < 75) ? kmer_pool[$urandom_range(0, 11)]
                                                : $urandom();
            send_request($urandom_range(0, 1) ? FUNC_FIND : FUNC_INSERT, kmer,
                         24'($urandom()));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes, a missing key and a value list that overflows.
        send_request(FUNC_INSERT, 32'h0, 24'h0);
        send_request(FUNC_INSERT, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_request(FUNC_FIND, 32'h0, 24'hFF_FFFF);
        send_request(FUNC_FIND, 32'hFFFF_FFFF, 24'h0);
        send_request(FUNC_FIND, 32'h1234_5678, 24'h0);
        for (int i = 0; i < 9; i++)
            send_request(FUNC_INSERT, 32'hA5A5_5A5A, 24'(i * 24'h11_1111));
        send_request(FUNC_FIND, 32'hA5A5_5A5A, 24'h0);

        // Two slots with one key allowed: the key count kept from earlier inserts refuses both new keys.
        set_table(5'd1, 4'd1, 10'd1);
        send_request(FUNC_INSERT, 32'h2, 24'h7);
        send_request(FUNC_INSERT, 32'h3, 24'h8);
        send_request(FUNC_FIND, 32'h0, 24'h0);
        // A key limit of zero refuses every new key; length zero acts as one base.
        set_table(5'd0, 4'd0, 10'd0);
        send_request(FUNC_INSERT, 32'hFFFF_FFF1, 24'h1);
        send_request(FUNC_FIND, 32'h1, 24'h0);
        // Inserts into four slots and then two; the key count from earlier inserts refuses each new key.
        set_table(5'd2, 4'd2, 10'd1023);
        send_request(FUNC_INSERT, 32'h5, 24'h10);
        send_request(FUNC_INSERT, 32'h9, 24'h11);
        set_table(5'd2, 4'd1, 10'd1023);
        send_request(FUNC_FIND, 32'h7, 24'h0);
        send_request(FUNC_INSERT, 32'h7, 24'h12);

        // Random traffic under a series of settings, saturating ones included.
        set_table(5'd16, 4'd10, 10'd512);
        random_phase(50);
        set_table(5'd1, 4'd1, 10'd1);
        random_phase(40);
        set_table(5'd3, 4'd4, 10'd12);
        random_phase(50);
        calm <= 1'b1;
        set_table(5'd31, 4'd15, 10'd1023);
        random_phase(60);
        calm <= 1'b0;
        set_table(5'd2, 4'd3, 10'd7);
        random_phase(50);
        set_table(5'd8, 4'd6, 10'd40);
        random_phase(50);
        set_table(5'($urandom_range(0, 31)), 4'($urandom_range(0, 15)),
                  10'($urandom_range(0, 1023)));
        random_phase(50);
        set_table(5'd16, 4'd10, 10'd1023);
        random_phase(50);

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/klpi_pkg.sv
sv/klpi_stream_if.sv
sv/klpi_datapath.sv
sv/klpi_ctrl.sv
sv/kmer_linear_probe_index.sv
test/tb_kmer_types_pkg.sv
test/tb_kmer_index_checker.sv
test/tb_top.sv
